// ===== hw/rtl/tfn_pkg.sv =====
// Shared types and constants of the triangle face normal block.
package tfn_pkg;

    // Vertex table geometry.
    localparam int VERT_DEPTH = 4096;
    localparam int VERT_AW    = $clog2(VERT_DEPTH);

    // Field widths.
    localparam int IDX_W   = 12;
    localparam int COORD_W = 24;
    localparam int NRM_W   = 16;

    // Face queue between the fetch front and the arithmetic back.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    // Request kinds.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_FACE = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [NRM_W-1:0]   nrm_t;
    typedef logic [IDX_W-1:0]          idx_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vert_t;

    localparam int VERT_W = $bits(vert_t);

    typedef struct packed {
        logic   req_type;
        idx_t   load_index;
        coord_t load_x;
        coord_t load_y;
        coord_t load_z;
        idx_t   corner_a_index;
        idx_t   corner_b_index;
        idx_t   corner_c_index;
        logic   final_face;
    } req_t;

    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
        nrm_t   normal_x;
        nrm_t   normal_y;
        nrm_t   normal_z;
        logic   degenerate;
        logic   last_corner;
        logic   mesh_end;
    } rsp_t;

    // A face with its three fetched corner positions.
    typedef struct packed {
        vert_t a;
        vert_t b;
        vert_t c;
        logic  final_face;
    } face_t;

    // Queue side band between front and back.
    typedef struct packed {
        logic  push;
        face_t face;
    } q_wr_t;

    // True when a table index names an existing slot.
    function automatic logic idx_in_range(input idx_t idx);
        idx_in_range = (int'(idx) < VERT_DEPTH);
    endfunction

endpackage

// ===== hw/rtl/tfn_ram.sv =====
// Generic single write, single read RAM with registered read data.
module tfn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tfn_front.sv =====
// Front part: accepts items, writes the vertex table and fetches face corners.
module tfn_front import tfn_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_t             req,
    input  logic [QCW-1:0]   q_count,
    output q_wr_t            q_wr
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_RDB  = 3'b010,
        F_RDC  = 3'b100
    } fstate_t;

    fstate_t            state_reg, state_next;
    logic               push_reg, push_next;
    idx_t               b_idx_reg, c_idx_reg;
    logic               ok_a_reg;
    logic               final_reg;
    vert_t              pa_reg, pb_reg;
    logic               accept, is_face, room;
    logic [QCW:0]       level;
    logic               we;
    logic [VERT_AW-1:0] waddr, raddr;
    vert_t              wdata, rdata;
    idx_t               ridx;

    // A face needs a queue slot, counting the one being pushed now.
    assign level     = {1'b0, q_count} + (QCW+1)'(push_reg);
    assign room      = (level < (QCW+1)'(QDEPTH));
    assign is_face   = (req.req_type == REQ_FACE);
    assign req_stall = (state_reg != F_IDLE) || (is_face && !room);
    assign accept    = req_valid && !req_stall;

    // Table write for load items.
    assign we      = accept && !is_face && idx_in_range(req.load_index);
    assign waddr   = VERT_AW'(req.load_index);
    assign wdata.x = req.load_x;
    assign wdata.y = req.load_y;
    assign wdata.z = req.load_z;

    // Read address follows the fetch sequence a, b, c.
    always_comb
    begin
        unique case (state_reg)
            F_IDLE:  ridx = req.corner_a_index;
            F_RDB:   ridx = b_idx_reg;
            F_RDC:   ridx = c_idx_reg;
            default: ridx = req.corner_a_index;
        endcase
    end

    assign raddr = VERT_AW'(ridx);

    tfn_ram #(
        .WIDTH (VERT_W),
        .DEPTH (VERT_DEPTH)
    ) u_vert_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Fetch sequencer.
    always_comb
    begin
        state_next = state_reg;
        push_next  = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept && is_face)
                begin
                    state_next = F_RDB;
                end
            end
            F_RDB:   state_next = F_RDC;
            F_RDC:
            begin
                state_next = F_IDLE;
                push_next  = 1'b1;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            push_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            push_reg  <= push_next;
        end
    end

    // Face indices and corner positions as they come out of the table.
    always_ff @(posedge clk)
    begin
        if (accept && is_face)
        begin
            b_idx_reg <= req.corner_b_index;
            c_idx_reg <= req.corner_c_index;
            ok_a_reg  <= idx_in_range(req.corner_a_index);
            final_reg <= req.final_face;
        end
        if (state_reg == F_RDB)
        begin
            pa_reg <= ok_a_reg ? rdata : '0;
        end
        if (state_reg == F_RDC)
        begin
            pb_reg <= idx_in_range(b_idx_reg) ? rdata : '0;
        end
    end

    // The third corner goes straight into the queue with the other two.
    assign q_wr.push            = push_reg;
    assign q_wr.face.a          = pa_reg;
    assign q_wr.face.b          = pb_reg;
    assign q_wr.face.c          = idx_in_range(c_idx_reg) ? rdata : '0;
    assign q_wr.face.final_face = final_reg;

endmodule

// ===== hw/rtl/tfn_fifo.sv =====
// Short face queue between the front and the back.
module tfn_fifo import tfn_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  q_wr_t          q_wr,
    input  logic           pop,
    output logic           head_valid,
    output face_t          head,
    output logic [QCW-1:0] count
);

    face_t          mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0] count_reg;
    logic           do_pop;

    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop && head_valid;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            mem_reg[wr_ptr_reg] <= q_wr.face;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_wr.push)
            begin
                wr_ptr_reg <= QAW'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= QAW'(rd_ptr_reg + 1'b1);
            end
            count_reg <= QCW'(count_reg + QCW'(q_wr.push) - QCW'(do_pop));
        end
    end

endmodule

// ===== hw/rtl/tfn_back.sv =====
// Back part: cross product, bit-serial normalization and corner emission.
module tfn_back import tfn_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  head_valid,
    input  face_t head,
    output logic  pop,
    output logic  rsp_valid,
    input  logic  rsp_stall,
    output rsp_t  rsp
);

    localparam int EDGE_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = PROD_W;
    localparam int NB      = 29;
    localparam int NM_W    = NB + 1;
    localparam int SQ_W    = 2 * NM_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int QB      = 16;
    localparam int DD_W    = NM_W + 16;
    localparam int DREM_W  = ROOT_W;
    localparam int ROOT_LAST = ROOT_W - 1;
    localparam int DIV_LAST  = QB - 1;
    localparam logic [QB-1:0] NRM_MAX = QB'(32767);

    typedef enum logic [10:0] {
        B_IDLE = 11'b00000000001,
        B_MUL  = 11'b00000000010,
        B_SUB  = 11'b00000000100,
        B_ABS  = 11'b00000001000,
        B_NORM = 11'b00000010000,
        B_SQR  = 11'b00000100000,
        B_SUM  = 11'b00001000000,
        B_ROOT = 11'b00010000000,
        B_DIVI = 11'b00100000000,
        B_DIV  = 11'b01000000000,
        B_DONE = 11'b10000000000
    } bstate_t;

    bstate_t                   state_reg, state_next;
    face_t                     face_reg;
    logic signed [EDGE_W-1:0]  e1_reg [3];
    logic signed [EDGE_W-1:0]  e2_reg [3];
    logic signed [PROD_W-1:0]  prod_reg [6];
    logic signed [CROSS_W-1:0] n_reg [3];
    logic [MAG_W-1:0]          mag_reg [3];
    logic                      neg_reg [3];
    logic                      deg_reg;
    logic [SQ_W-1:0]           sq_reg [3];
    logic [SUM_W-1:0]          s_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic [4:0]                cnt_reg;
    logic [DREM_W-1:0]         drem_reg [3];
    logic [QB-1:0]             dlow_reg [3];

    // Output stage.
    logic                      ovalid_reg;
    logic [1:0]                corner_reg;
    vert_t                     opos_reg [3];
    nrm_t                      onrm_reg [3];
    logic                      odeg_reg;
    logic                      ofinal_reg;

    logic                      mag_hi, mag_top, mag_zero;
    logic [REM_W+1:0]          rem4, trial;
    logic                      root_ge;
    logic [DD_W-1:0]           dd [3];
    logic [DREM_W:0]           dtry [3];
    logic                      dge [3];
    logic [QB-1:0]             qsat [3];
    nrm_t                      nrm [3];
    logic                      rsp_take, out_free, load_out;

    assign pop      = (state_reg == B_IDLE) && head_valid;
    assign rsp_take = ovalid_reg && !rsp_stall;
    assign out_free = !ovalid_reg || (rsp_take && (corner_reg == 2'd2));
    assign load_out = (state_reg == B_DONE) && out_free;

    // Normalization window checks on the three magnitudes.
    assign mag_hi   = (mag_reg[0][MAG_W-1:NM_W] != '0) || (mag_reg[1][MAG_W-1:NM_W] != '0)
                   || (mag_reg[2][MAG_W-1:NM_W] != '0);
    assign mag_top  = mag_reg[0][NB] || mag_reg[1][NB] || mag_reg[2][NB];
    assign mag_zero = (mag_reg[0] == '0) && (mag_reg[1] == '0) && (mag_reg[2] == '0);

    // One step of the digit-by-digit square root.
    assign rem4    = {rem_reg, s_reg[SUM_W-1 -: 2]};
    assign trial   = (REM_W+2)'({root_reg, 2'b01});
    assign root_ge = (rem4 >= trial);

    // Per-lane dividend setup with rounding, divide step and output saturation and sign.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dd[i]   = DD_W'({mag_reg[i][NM_W-1:0], 15'd0}) + DD_W'(root_reg >> 1);
            dtry[i] = {drem_reg[i], dlow_reg[i][QB-1]};
            dge[i]  = (dtry[i] >= (DREM_W+1)'(root_reg));
            qsat[i] = (dlow_reg[i] > NRM_MAX) ? NRM_MAX : dlow_reg[i];
            if (deg_reg)
            begin
                nrm[i] = '0;
            end
            else if (neg_reg[i])
            begin
                nrm[i] = -nrm_t'(qsat[i]);
            end
            else
            begin
                nrm[i] = nrm_t'(qsat[i]);
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = B_MUL;
                end
            end
            B_MUL:   state_next = B_SUB;
            B_SUB:   state_next = B_ABS;
            B_ABS:   state_next = B_NORM;
            B_NORM:
            begin
                if (mag_zero)
                begin
                    state_next = B_DONE;
                end
                else if (!mag_hi && mag_top)
                begin
                    state_next = B_SQR;
                end
            end
            B_SQR:   state_next = B_SUM;
            B_SUM:   state_next = B_ROOT;
            B_ROOT:
            begin
                if (cnt_reg == 5'(ROOT_LAST))
                begin
                    state_next = B_DIVI;
                end
            end
            B_DIVI:  state_next = B_DIV;
            B_DIV:
            begin
                if (cnt_reg == 5'(DIV_LAST))
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers of the normal computation.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                face_reg  <= head;
                deg_reg   <= 1'b0;
                e1_reg[0] <= EDGE_W'(head.b.x) - EDGE_W'(head.a.x);
                e1_reg[1] <= EDGE_W'(head.b.y) - EDGE_W'(head.a.y);
                e1_reg[2] <= EDGE_W'(head.b.z) - EDGE_W'(head.a.z);
                e2_reg[0] <= EDGE_W'(head.c.x) - EDGE_W'(head.a.x);
                e2_reg[1] <= EDGE_W'(head.c.y) - EDGE_W'(head.a.y);
                e2_reg[2] <= EDGE_W'(head.c.z) - EDGE_W'(head.a.z);
            end
            B_MUL:
            begin
                prod_reg[0] <= e1_reg[1] * e2_reg[2];
                prod_reg[1] <= e1_reg[2] * e2_reg[1];
                prod_reg[2] <= e1_reg[2] * e2_reg[0];
                prod_reg[3] <= e1_reg[0] * e2_reg[2];
                prod_reg[4] <= e1_reg[0] * e2_reg[1];
                prod_reg[5] <= e1_reg[1] * e2_reg[0];
            end
            B_SUB:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    n_reg[i] <= CROSS_W'(prod_reg[2*i]) - CROSS_W'(prod_reg[2*i+1]);
                end
            end
            B_ABS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= n_reg[i][CROSS_W-1];
                    mag_reg[i] <= MAG_W'(n_reg[i][CROSS_W-1] ? -n_reg[i] : n_reg[i]);
                end
            end
            B_NORM:
            begin
                // Bring the largest magnitude's top bit to the window bit.
                if (mag_zero)
                begin
                    deg_reg <= 1'b1;
                end
                else if (mag_hi)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
                else if (!mag_top)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            B_SQR:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[i] <= mag_reg[i][NM_W-1:0] * mag_reg[i][NM_W-1:0];
                end
            end
            B_SUM:
            begin
                s_reg    <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            B_ROOT:
            begin
                s_reg   <= s_reg << 2;
                cnt_reg <= 5'(cnt_reg + 1'b1);
                if (root_ge)
                begin
                    rem_reg  <= REM_W'(rem4 - trial);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= REM_W'(rem4);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            B_DIVI:
            begin
                cnt_reg <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[i] <= DREM_W'(dd[i][DD_W-1:QB]);
                    dlow_reg[i] <= dd[i][QB-1:0];
                end
            end
            B_DIV:
            begin
                cnt_reg <= 5'(cnt_reg + 1'b1);
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[i] <= dge[i] ? DREM_W'(dtry[i] - (DREM_W+1)'(root_reg))
                                          : DREM_W'(dtry[i]);
                    dlow_reg[i] <= {dlow_reg[i][QB-2:0], dge[i]};
                end
            end
            B_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output stage control: three corners per face.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            corner_reg <= '0;
        end
        else
        begin
            if (rsp_take)
            begin
                if (corner_reg == 2'd2)
                begin
                    ovalid_reg <= 1'b0;
                    corner_reg <= '0;
                end
                else
                begin
                    corner_reg <= 2'(corner_reg + 1'b1);
                end
            end
            if (load_out)
            begin
                ovalid_reg <= 1'b1;
                corner_reg <= '0;
            end
        end
    end

    // Output stage payload of the face being emitted.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            opos_reg[0] <= face_reg.a;
            opos_reg[1] <= face_reg.b;
            opos_reg[2] <= face_reg.c;
            for (int i = 0; i < 3; i++)
            begin
                onrm_reg[i] <= nrm[i];
            end
            odeg_reg   <= deg_reg;
            ofinal_reg <= face_reg.final_face;
        end
    end

    // Result item for the current corner.
    always_comb
    begin
        rsp.pos_x       = opos_reg[corner_reg].x;
        rsp.pos_y       = opos_reg[corner_reg].y;
        rsp.pos_z       = opos_reg[corner_reg].z;
        rsp.normal_x    = onrm_reg[0];
        rsp.normal_y    = onrm_reg[1];
        rsp.normal_z    = onrm_reg[2];
        rsp.degenerate  = odeg_reg;
        rsp.last_corner = (corner_reg == 2'd2);
        rsp.mesh_end    = (corner_reg == 2'd2) && ofinal_reg;
    end

    assign rsp_valid = ovalid_reg;

endmodule

// ===== hw/rtl/triangle_face_normal.sv =====
// Top level of the triangle face normal block.
//
// Items enter on the req channel (req_valid, req_stall, req). A load item
// writes one vertex into the 4096 entry table, so loads can be taken every
// cycle while no face fetch holds req_stall. A face item reads its three
// corners from the single table read port, which holds req_stall high while
// corners b and c are read; a face also waits for a free queue slot.
// Fetched faces wait in a four entry queue. The back part works one face at
// a time: edges, cross product, a one bit a cycle normalizing shift, a
// digit-by-digit square root and a three lane divider; these serial units
// set the sustained face rate, and a zero cross product goes straight to the
// output without the root and the divider.
// Each face then gives three corner items on the rsp channel (rsp_valid,
// rsp_stall, rsp) in corners a, b, c order, one per cycle while the receiver
// does not stall; the next face is computed while they drain. A stalled
// result holds its payload.
// Reset empties the queue and the output stage; the vertex table content is
// unknown until it is loaded, and corners must only name loaded entries.
module triangle_face_normal import tfn_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    q_wr_t          q_wr;
    logic [QCW-1:0] q_count;
    logic           q_pop;
    logic           head_valid;
    face_t          head;

    // Accept, table writes and corner fetch.
    tfn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_count   (q_count),
        .q_wr      (q_wr)
    );

    // Queue of fetched faces.
    tfn_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_wr       (q_wr),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (q_count)
    );

    // Normal computation and corner output.
    tfn_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (q_pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

// ===== hw/rtl/tfn_checker.sv =====
// Port level checks of the triangle face normal block, bound to the top level.
module tfn_checker import tfn_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // A stalled result item keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    // Corner fetch occupies the input after a face item.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.req_type == REQ_FACE) |=> req_stall)
        else $error("input taken during corner fetch");

    // The next corner of a face follows at once with the same normal.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall && !rsp.last_corner
        |=> rsp_valid && $stable(rsp.normal_x) && $stable(rsp.normal_y)
            && $stable(rsp.normal_z) && $stable(rsp.degenerate))
        else $error("corner items of one face differ in normal");

    // A degenerate face carries a zero normal.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.degenerate
        |-> (rsp.normal_x == '0) && (rsp.normal_y == '0) && (rsp.normal_z == '0))
        else $error("degenerate face with nonzero normal");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (.*);
